>>> sv/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int LS_AW       = $clog2(MAX_WIDTH);
  localparam int EW          = LS_AW + 1;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int TW          = EW + HEIGHT_BITS;
  localparam int CFG_AW      = 3;
  localparam int WIN_N       = 3;
  localparam int SUM_W       = 12;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 12'd480;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } bb3_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } bb3_out_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } bb3_col_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } bb3_line_t;

  typedef struct packed {
    logic emit;
    logic frame_end;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } bb3_ctl_t;

endpackage

`default_nettype wire

>>> sv/bb3_col_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bb3_col_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  bb3_pkg::bb3_col_t  col_in,
  output bb3_pkg::bb3_col_t  col_out
);
  import bb3_pkg::*;

  bb3_col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

>>> sv/bb3_mean.sv
`timescale 1ns / 1ps
`default_nettype none

module bb3_mean (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   advance,
  input  logic                                   win_valid,
  input  bb3_pkg::bb3_ctl_t                      ctl,
  input  bb3_pkg::bb3_col_t [bb3_pkg::WIN_N-1:0] win,
  output logic                                   out_valid,
  output bb3_pkg::bb3_out_t                      out_data
);
  import bb3_pkg::*;

  localparam logic [15:0] DIV3_M  = 16'd43691;
  localparam int          DIV3_SH = 17;
  localparam logic [15:0] DIV9_M  = 16'd58255;
  localparam int          DIV9_SH = 19;
  localparam int          PW      = SUM_W + 16;

  // rounded mean: floor((s + n/2) / n) for n in 1, 2, 3, 4, 6, 9
  function automatic logic [7:0] round_div(input logic [SUM_W-1:0] s, input logic [3:0] n);
    logic [SUM_W-1:0] y;
    logic [PW-1:0]    p;
    logic [7:0]       qv;
    y  = s + SUM_W'(n >> 1);
    p  = '0;
    qv = '0;
    unique case (n)
      4'd1: qv = 8'(y);
      4'd2: qv = 8'(y >> 1);
      4'd4: qv = 8'(y >> 2);
      4'd3: begin
        p  = PW'(y) * PW'(DIV3_M);
        qv = 8'(p >> DIV3_SH);
      end
      4'd6: begin
        p  = PW'(y >> 1) * PW'(DIV3_M);
        qv = 8'(p >> DIV3_SH);
      end
      4'd9: begin
        p  = PW'(y) * PW'(DIV9_M);
        qv = 8'(p >> DIV9_SH);
      end
      default: qv = 8'(y);
    endcase
    return qv;
  endfunction

  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [1:0]       rows_n;
  logic [1:0]       cols_n;
  logic [3:0]       n_c;
  pix_t             px;
  logic [SUM_W-1:0] sum_c [3];

  logic             sum_v_r;
  logic             sum_fe_r;
  logic [3:0]       n_r;
  logic [SUM_W-1:0] sum_r [3];

  logic             out_valid_r;
  bb3_out_t         out_data_r;

  always_comb begin
    row_ok = {ctl.bot_ok, 1'b1, ctl.top_ok};
    col_ok = {ctl.right_ok, 1'b1, ctl.left_ok};
    rows_n = 2'd1 + 2'(ctl.top_ok) + 2'(ctl.bot_ok);
    cols_n = 2'd1 + 2'(ctl.left_ok) + 2'(ctl.right_ok);
    n_c    = 4'(rows_n) * 4'(cols_n);
    px     = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int c = 0; c < WIN_N; c++) begin
        for (int r = 0; r < 3; r++) begin
          px = (r == 0) ? win[c].top : ((r == 1) ? win[c].mid : win[c].bot);
          if (row_ok[r] && col_ok[c]) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(px[(2 - ch) * 8 +: 8]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      sum_v_r     <= win_valid;
      out_valid_r <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_fe_r                 <= ctl.frame_end;
      n_r                      <= n_c;
      sum_r                    <= sum_c;
      out_data_r.red_out       <= round_div(sum_r[0], n_r);
      out_data_r.green_out     <= round_div(sum_r[1], n_r);
      out_data_r.blue_out      <= round_div(sum_r[2], n_r);
      out_data_r.frame_end     <= sum_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/box_blur_3x3_edge_aware_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// port group  dir  handshake                   beat
// in_         in   in_valid / in_stall         bb3_in_t: mode, red, green, blue
// out_        out  out_valid / out_stall       bb3_out_t: red, green, blue, frame_end
// apb         in   psel, penable, pwrite       image_width at 0x0, image_height at 0x4
//
// one beat per clock on both sides while out_stall is low; an accepted beat passes the line
// store read at the accept edge, then window shift, neighbor sum and divide before out_data
// both line stores share one 1024 x 48 memory; a read of the column being written in the
// same cycle takes the bypass path
// rst_n is synchronous, active low; the line memory is not cleared
// a stalled result freezes the pipeline and raises in_stall in the same cycle

module box_blur_3x3_edge_aware_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bb3_pkg::bb3_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bb3_pkg::bb3_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bb3_pkg::*;

  function automatic logic [EW-1:0] eff_width(input logic [WIDTH_BITS-1:0] raw);
    logic [EW-1:0] w;
    if (raw == '0) begin
      w = EW'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      w = EW'(MAX_WIDTH);
    end else begin
      w = EW'(raw);
    end
    return w;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] raw);
    return (raw == '0) ? HEIGHT_BITS'(1) : raw;
  endfunction

  function automatic logic [TW-1:0] frame_total(input logic [EW-1:0] w,
                                                input logic [HEIGHT_BITS-1:0] h);
    return TW'(w) * TW'(h);
  endfunction

  // configuration
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [TW-1:0]          total_r;
  logic [EW-1:0]          eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic                   cfg_wr;
  logic                   cfg_idx;

  // position counters
  logic [TW-1:0]          q_r;
  logic [LS_AW-1:0]       col_r;
  logic [LS_AW-1:0]       ecol_r;
  logic [HEIGHT_BITS-1:0] erow_r;

  // front end
  logic     advance;
  logic     accept;
  logic     past_end;
  logic     ignore;
  logic     take;
  logic     col_last;
  logic     ecol_last;
  logic     erow_last;
  logic     frame_done;
  bb3_ctl_t ctl;
  pix_t     pix;

  // line store stage
  bb3_line_t        line_mem [MAX_WIDTH];
  logic             s1_v_r;
  pix_t             s1_pix_r;
  logic [LS_AW-1:0] s1_col_r;
  bb3_ctl_t         s1_ctl_r;
  bb3_line_t        line_rd_r;
  logic             byp_hit_r;
  bb3_line_t        byp_data_r;
  bb3_line_t        line_eff;
  bb3_line_t        line_wr;
  logic             line_we;

  // window
  bb3_col_t             new_col;
  bb3_col_t [WIN_N-1:0] win;
  bb3_col_t [WIN_N-1:0] win_in;
  logic                 s2_v_r;
  bb3_ctl_t             s2_ctl_r;

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[2];
  assign pready  = 1'b1;
  assign eff_w   = eff_width(width_r);
  assign eff_h   = eff_height(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      total_r  <= frame_total(eff_width(WIDTH_RST), eff_height(HEIGHT_RST));
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH: begin
          width_r <= pwdata[WIDTH_BITS-1:0];
          total_r <= frame_total(eff_width(pwdata[WIDTH_BITS-1:0]), eff_h);
        end
        REG_HEIGHT: begin
          height_r <= pwdata[HEIGHT_BITS-1:0];
          total_r  <= frame_total(eff_w, eff_height(pwdata[HEIGHT_BITS-1:0]));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign past_end   = q_r >= total_r;
  assign ignore     = in_data.mode && !past_end;
  assign take       = accept && !ignore;
  assign col_last   = (EW'(col_r) + EW'(1)) == eff_w;
  assign ecol_last  = (EW'(ecol_r) + EW'(1)) == eff_w;
  assign erow_last  = erow_r == (eff_h - HEIGHT_BITS'(1));

  always_comb begin
    ctl.emit      = q_r >= (TW'(eff_w) + TW'(1));
    frame_done    = ctl.emit && erow_last && ecol_last;
    ctl.frame_end = frame_done;
    ctl.top_ok    = erow_r != '0;
    ctl.bot_ok    = !erow_last;
    ctl.left_ok   = ecol_r != '0;
    ctl.right_ok  = !ecol_last;
    pix           = past_end ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      q_r    <= '0;
      col_r  <= '0;
      ecol_r <= '0;
      erow_r <= '0;
    end else if (take) begin
      if (frame_done) begin
        q_r    <= '0;
        col_r  <= '0;
        ecol_r <= '0;
        erow_r <= '0;
      end else begin
        q_r   <= q_r + TW'(1);
        col_r <= col_last ? '0 : col_r + LS_AW'(1);
        if (ctl.emit) begin
          ecol_r <= ecol_last ? '0 : ecol_r + LS_AW'(1);
          if (ecol_last) begin
            erow_r <= erow_r + HEIGHT_BITS'(1);
          end
        end
      end
    end
  end

  // line store read and write-back
  assign line_eff        = byp_hit_r ? byp_data_r : line_rd_r;
  assign line_wr.upper   = line_eff.middle;
  assign line_wr.middle  = s1_pix_r;
  assign line_we         = advance && s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix_r   <= pix;
      s1_col_r   <= col_r;
      s1_ctl_r   <= ctl;
      line_rd_r  <= line_mem[col_r];
      byp_hit_r  <= s1_v_r && (s1_col_r == col_r);
      byp_data_r <= line_wr;
      s2_ctl_r   <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[s1_col_r] <= line_wr;
    end
  end

  // window columns
  assign new_col.top = line_eff.upper;
  assign new_col.mid = line_eff.middle;
  assign new_col.bot = s1_pix_r;

  assign win_in[WIN_N-1] = new_col;

  for (genvar k = 0; k < WIN_N; k++) begin : g_cell
    if (k < WIN_N - 1) begin : g_link
      assign win_in[k] = win[k+1];
    end
    bb3_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (line_we),
      .col_in   (win_in[k]),
      .col_out  (win[k])
    );
  end

  bb3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .win_valid (s2_v_r),
    .ctl       (s2_ctl_r),
    .win       (win),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_frozen_no_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !line_we)
    else $error("line store written while pipeline is frozen");

  a_counters_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (EW'(col_r) < eff_w) && (EW'(ecol_r) < eff_w) && (erow_r < eff_h))
    else $error("position counter outside the frame");

  a_ignored_drain_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ignore) |=> !s1_v_r)
    else $error("early drain beat entered the pipeline");

endmodule

`default_nettype wire
